[hdl/dfmod_pkg.sv]
// ---------------------------------------------------------------------------
// dfmod_pkg: shared types and constants for the binary64 fmod unit
// Holds the field constants and the command and status structs.
// ---------------------------------------------------------------------------
package dfmod_pkg;

   localparam int unsigned ExpBits  = 11;
   localparam int unsigned FracBits = 52;
   localparam int unsigned SigBits  = 53;
   localparam int unsigned ExpWidth = 13;   // signed working exponent

   localparam logic [ExpBits-1:0] ExpAllOnes = 11'h7FF;
   localparam logic [63:0] DefaultNan = 64'h7FF8_0000_0000_0000;
   localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;

   typedef struct packed {
      logic load;     // capture operands and classify
      logic norm;     // one normalisation step on both operands
      logic step;     // one shift-subtract step
      logic fin;      // final compare-subtract
      logic renorm;   // one left shift of the rest
      logic pack;     // form the result
   } dfmod_cmd_type;

   typedef struct packed {
      logic special;    // result settled at load
      logic norm_done;  // both significands normalised
      logic loop_done;  // exponent difference used up
      logic zero_rest;  // exact multiple found
      logic renorm_done;
   } dfmod_stat_type;

endpackage

[hdl/dfmod_if.sv]
// ---------------------------------------------------------------------------
// dfmod_if: valid/ready channel
// Carries one item with a generic payload.
// ---------------------------------------------------------------------------
interface dfmod_if #(
   parameter int unsigned WIDTH = 128
);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hdl/dfmod_datapath.sv]
// ---------------------------------------------------------------------------
// dfmod_datapath: operand registers and shift-subtract unit
// Normalises, reduces and packs under command of the controller.
// ---------------------------------------------------------------------------
module dfmod_datapath (
   input  logic                     clock,
   input  logic [63:0]              x_bits,
   input  logic [63:0]              y_bits,
   input  dfmod_pkg::dfmod_cmd_type cmd,
   output dfmod_pkg::dfmod_stat_type stat,
   output logic [63:0]              result,
   output logic                     result_invalid
);
   localparam int unsigned EW = dfmod_pkg::ExpWidth;

   logic [63:0]   mx_ff, mx_in, my_ff, my_in;
   logic [EW-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic          sign_ff, sign_in;
   logic          special_ff, special_in;
   logic          zero_ff, zero_in;
   logic [63:0]   sres_ff, sres_in;
   logic          sinv_ff, sinv_in;
   logic [63:0]   res_ff, res_in;
   logic          inv_ff, inv_in;

   logic          x_nan, y_nan, x_ex_ones;
   logic [63:0]   d;
   logic [63:0]   sub_mx;
   logic [EW-1:0] sh;
   logic [63:0]   packed_mag;

   assign x_nan = (x_bits << 1) > (64'h7FF0_0000_0000_0000 << 1);
   assign y_nan = (y_bits << 1) > (64'h7FF0_0000_0000_0000 << 1);
   assign x_ex_ones = (x_bits[62:52] == dfmod_pkg::ExpAllOnes);
   assign d = mx_ff - my_ff;
   assign sub_mx = (d[63] == 1'b0) ? d : mx_ff;
   assign sh = EW'(1) - ex_ff;

   always_comb begin
      if ($signed(ex_ff) > $signed(EW'(0))) begin
         packed_mag = (mx_ff - 64'h0010_0000_0000_0000) | {1'b0, ex_ff[10:0], 52'd0};
      end else begin
         packed_mag = (sh > EW'(63)) ? 64'd0 : (mx_ff >> sh[5:0]);
      end
   end

   always_comb begin
      mx_in = mx_ff; my_in = my_ff; ex_in = ex_ff; ey_in = ey_ff;
      sign_in = sign_ff; special_in = special_ff; zero_in = zero_ff;
      sres_in = sres_ff; sinv_in = sinv_ff; res_in = res_ff; inv_in = inv_ff;
      if (cmd.load) begin
         sign_in    = x_bits[63];
         zero_in    = 1'b0;
         sinv_in    = 1'b0;
         special_in = 1'b1;
         mx_in = {11'd0, (x_bits[62:52] != 11'd0), x_bits[51:0]};
         my_in = {11'd0, (y_bits[62:52] != 11'd0), y_bits[51:0]};
         ex_in = (x_bits[62:52] == 11'd0) ? EW'(1) : {2'b00, x_bits[62:52]};
         ey_in = (y_bits[62:52] == 11'd0) ? EW'(1) : {2'b00, y_bits[62:52]};
         if ((y_bits[62:0] == 63'd0) || y_nan || x_ex_ones) begin
            sinv_in = 1'b1;
            if (x_nan) sres_in = x_bits | dfmod_pkg::QuietBit;
            else if (y_nan) sres_in = y_bits | dfmod_pkg::QuietBit;
            else sres_in = dfmod_pkg::DefaultNan;
         end else if (x_bits[62:0] == y_bits[62:0]) begin
            sres_in = {x_bits[63], 63'd0};
         end else if (x_bits[62:0] < y_bits[62:0]) begin
            sres_in = x_bits;
         end else begin
            special_in = 1'b0;
            sres_in = x_bits;
         end
      end
      if (cmd.norm) begin
         if (mx_ff[52] == 1'b0) begin
            mx_in = mx_ff << 1; ex_in = ex_ff - EW'(1);
         end
         if (my_ff[52] == 1'b0) begin
            my_in = my_ff << 1; ey_in = ey_ff - EW'(1);
         end
      end
      if (cmd.step) begin
         if (d == 64'd0) zero_in = 1'b1;
         mx_in = sub_mx << 1;
         ex_in = ex_ff - EW'(1);
      end
      if (cmd.fin) begin
         if (d == 64'd0) zero_in = 1'b1;
         mx_in = sub_mx;
      end
      if (cmd.renorm) begin
         mx_in = mx_ff << 1;
         ex_in = ex_ff - EW'(1);
      end
      if (cmd.pack) begin
         inv_in = special_ff ? sinv_ff : 1'b0;
         if (special_ff) res_in = sres_ff;
         else if (zero_ff) res_in = {sign_ff, 63'd0};
         else res_in = {sign_ff, packed_mag[62:0]};
      end
   end

   always_ff @(posedge clock) begin
      mx_ff <= mx_in; my_ff <= my_in; ex_ff <= ex_in; ey_ff <= ey_in;
      sign_ff <= sign_in; special_ff <= special_in; zero_ff <= zero_in;
      sres_ff <= sres_in; sinv_ff <= sinv_in; res_ff <= res_in; inv_ff <= inv_in;
   end

   assign stat.special     = special_ff;
   assign stat.norm_done   = mx_ff[52] & my_ff[52];
   assign stat.loop_done   = !($signed(ex_ff) > $signed(ey_ff));
   assign stat.zero_rest   = zero_ff;
   assign stat.renorm_done = mx_ff[52];
   assign result           = res_ff;
   assign result_invalid   = inv_ff;
endmodule

[hdl/dfmod_control.sv]
// ---------------------------------------------------------------------------
// dfmod_control: sequencer for the fmod unit
// Walks load, normalise, reduce, renormalise and pack; owns the handshake.
// ---------------------------------------------------------------------------
module dfmod_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   output logic                      out_valid,
   input  logic                      out_ready,
   input  dfmod_pkg::dfmod_stat_type stat,
   output dfmod_pkg::dfmod_cmd_type  cmd
);
   typedef enum logic [6:0] {
      IDLE   = 7'b0000001,
      CLASS  = 7'b0000010,
      NORM   = 7'b0000100,
      STEP   = 7'b0001000,
      FIN    = 7'b0010000,
      RENORM = 7'b0100000,
      PACK   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   assign in_ready  = (state_ff == IDLE) && !valid_ff;
   assign out_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !out_ready;
      cmd = '0;
      case (state_ff)
         IDLE: begin
            cmd.load = in_valid && in_ready;
            if (in_valid && in_ready) state_in = CLASS;
         end
         CLASS:  state_in = stat.special ? PACK : NORM;
         NORM: begin
            if (stat.norm_done) state_in = STEP;
            else cmd.norm = 1'b1;
         end
         STEP: begin
            if (stat.zero_rest) state_in = PACK;
            else if (stat.loop_done) state_in = FIN;
            else cmd.step = 1'b1;
         end
         FIN: begin
            cmd.fin = 1'b1;
            state_in = RENORM;
         end
         RENORM: begin
            if (stat.zero_rest || stat.renorm_done) state_in = PACK;
            else cmd.renorm = 1'b1;
         end
         PACK: begin
            cmd.pack = 1'b1;
            valid_in = 1'b1;
            state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end
endmodule

[hdl/double_fmod_remainder_unit.sv]
// Sequence: load and classify; special operands then go straight to pack, others are
// normalised, reduced by shift-subtract steps, finally compared and renormalised.
// Throughput: one item at a time; the shift-subtract loop sets the rate.
// The next item is taken once the previous result has been collected.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
// double_fmod_remainder_unit: binary64 truncated remainder
// Top level: joins the sequencer and the datapath to the two channels.
// ---------------------------------------------------------------------------
module double_fmod_remainder_unit (
   input  logic   clock,
   input  logic   reset,
   dfmod_if.sink  req,
   dfmod_if.source rsp
);
   dfmod_pkg::dfmod_cmd_type  cmd;
   dfmod_pkg::dfmod_stat_type stat;

   // req payload: dividend in the upper word, divisor in the lower
   // rsp payload: invalid in bit 64, remainder below
   logic [63:0] result;
   logic        result_invalid;

   dfmod_control u_control (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dfmod_datapath u_datapath (
      .clock          (clock),
      .x_bits         (req.payload[127:64]),
      .y_bits         (req.payload[63:0]),
      .cmd            (cmd),
      .stat           (stat),
      .result         (result),
      .result_invalid (result_invalid)
   );

   // hold the result in the datapath register until the item is taken
   assign rsp.payload = {result_invalid, result};

   // never take a new item while a result still waits
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("item taken while result pending");

   // an unaccepted result keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(rsp.payload))
      else $error("result changed while stalled");

   // invalid only goes with the all-ones exponent of a NaN pattern
   a_inv_nan: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload[64] |-> rsp.payload[62:52] == 11'h7FF)
      else $error("invalid without NaN");
endmodule
